### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, switched off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/uttp_pkg.sv
package uttp_pkg;

  localparam int TABLE_BYTES = 48;
  localparam int PASS_LEN    = 5;

  localparam logic [15:0] TABLE_LEN  = 16'(TABLE_BYTES);
  localparam logic [7:0]  COUNT_BYTE = 8'(TABLE_BYTES / 8);

  localparam logic [7:0] CMD_READ  = 8'h72;
  localparam logic [7:0] CMD_WRITE = 8'h77;
  localparam logic [7:0] CMD_COUNT = 8'h71;
  localparam logic [7:0] ACK_A     = 8'hAA;
  localparam logic [7:0] ACK_B     = 8'h55;

  // Two banks of the table share one memory; the active bank is swapped on a
  // successful write instead of copying.
  localparam int MEM_DEPTH = 2 * TABLE_BYTES;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int STEP_W    = $clog2(TABLE_BYTES + 4);

  function automatic logic [7:0] pass_byte(logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'd2;
      3'd1:    val = 8'd6;
      3'd2:    val = 8'd2;
      3'd3:    val = 8'd1;
      3'd4:    val = 8'd9;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

### rtl/unlocked_table_transfer_protocol.sv
// Password-guarded table transfer over a byte link.
// Received bytes enter on rx_byte with rx_valid/rx_ready; response bytes leave
// on tx_byte, last and table_updated with tx_valid/tx_ready. The password
// 2,6,2,1,9 unlocks the block; the next byte is a command: 0x72 reads the
// table (length, data, checksum: 52 bytes), 0x71 returns the length over 8,
// 0x77 writes the table followed by a checksum and answers AA 55 AA 55 on a
// match. Every non-final response byte is followed by another.
// After the command or final checksum transaction, the generator starts and
// the first response byte passes the memory read stage and the output register;
// following bytes come one per cycle while the receiver does not stall, from
// the table memory feeding a two-stage pipeline. Input bytes are taken one per
// cycle while no response is being generated; rx_ready stays low until the
// final byte of a response has left the memory read stage. A stalled receiver
// holds the output register and the read stage; nothing is lost or repeated.
// Synchronous reset relocks the block, empties the pipeline and makes the
// active table read as all zero; no clearing pass is needed.
module unlocked_table_transfer_protocol
  import uttp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       tx_valid,
  input  logic       tx_ready,
  output logic [7:0] tx_byte,
  output logic       last,
  output logic       table_updated
);

  localparam logic [1:0] PH_LOCKED = 2'd0;
  localparam logic [1:0] PH_CMD    = 2'd1;
  localparam logic [1:0] PH_RECV   = 2'd2;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_ACK   = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;

  localparam logic [1:0] KIND_CONST  = 2'd0;
  localparam logic [1:0] KIND_MEM    = 2'd1;
  localparam logic [1:0] KIND_SUM_LO = 2'd2;
  localparam logic [1:0] KIND_SUM_HI = 2'd3;

  function automatic logic [ADDR_W-1:0] tab_addr(logic bank_sel, logic [6:0] idx);
    logic [7:0] full;
    full = bank_sel ? ({1'b0, idx} + 8'(TABLE_BYTES)) : {1'b0, idx};
    return full[ADDR_W-1:0];
  endfunction

  logic [1:0]        phase, phase_next;
  logic [6:0]        position, position_next;
  logic [7:0]        recv_lo;
  logic [15:0]       recv_sum;
  logic              bank, bank_next;
  logic [1:0]        bank_ok, bank_ok_next;

  logic              gen_active, gen_start;
  logic [1:0]        gen_mode, gen_mode_start;
  logic [STEP_W-1:0] gstep;

  logic              s1_valid;
  logic [1:0]        s1_kind;
  logic [7:0]        s1_byte;
  logic              s1_last, s1_upd, s1_zero;
  logic [15:0]       sum;

  logic              accept, issue, s1_move;
  logic [1:0]        g_kind;
  logic [7:0]        g_byte, sel_byte, rd_data;
  logic              g_last, g_upd, g_final;
  logic              mem_we;
  logic [6:0]        rd_idx;

  assign rx_ready = !gen_active && !s1_valid;
  assign accept   = rx_valid && rx_ready;
  assign s1_move  = s1_valid && (!tx_valid || tx_ready);
  assign issue    = gen_active && (!s1_valid || s1_move);
  assign mem_we   = accept && (phase == PH_RECV) && (position < 7'(TABLE_BYTES));
  assign rd_idx   = 7'(gstep) - 7'd2;

  uttp_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(tab_addr(!bank, position)),
    .wdata(rx_byte),
    .re   (issue),
    .raddr(tab_addr(bank, rd_idx)),
    .rdata(rd_data)
  );

  always_comb begin
    phase_next     = phase;
    position_next  = position;
    bank_next      = bank;
    bank_ok_next   = bank_ok;
    gen_start      = 1'b0;
    gen_mode_start = MODE_READ;
    unique case (phase)
      PH_CMD: begin
        if (rx_byte == CMD_READ) begin
          gen_start      = 1'b1;
          gen_mode_start = MODE_READ;
          phase_next     = PH_LOCKED;
          position_next  = 7'd0;
        end else if (rx_byte == CMD_WRITE) begin
          phase_next    = PH_RECV;
          position_next = 7'd0;
        end else if (rx_byte == CMD_COUNT) begin
          gen_start      = 1'b1;
          gen_mode_start = MODE_COUNT;
          phase_next     = PH_LOCKED;
          position_next  = 7'd0;
        end
      end
      PH_RECV: begin
        position_next = position + 7'd1;
        if (position == 7'(TABLE_BYTES + 1)) begin
          phase_next    = PH_LOCKED;
          position_next = 7'd0;
          if ({rx_byte, recv_lo} == recv_sum) begin
            gen_start             = 1'b1;
            gen_mode_start        = MODE_ACK;
            bank_next             = !bank;
            bank_ok_next[!bank]   = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_LOCKED;
        if (position < 7'(PASS_LEN) && rx_byte == pass_byte(position[2:0])) begin
          position_next = position + 7'd1;
        end else begin
          position_next = 7'd0;
        end
        if (position_next == 7'(PASS_LEN)) begin
          phase_next    = PH_CMD;
          position_next = 7'd0;
        end
      end
    endcase
  end

  always_comb begin
    g_kind  = KIND_CONST;
    g_byte  = ACK_A;
    g_last  = 1'b0;
    g_upd   = 1'b0;
    g_final = 1'b0;
    unique case (gen_mode)
      MODE_READ: begin
        if (gstep == STEP_W'(0)) begin
          g_byte = TABLE_LEN[7:0];
        end else if (gstep == STEP_W'(1)) begin
          g_byte = TABLE_LEN[15:8];
        end else if (gstep < STEP_W'(TABLE_BYTES + 2)) begin
          g_kind = KIND_MEM;
        end else if (gstep == STEP_W'(TABLE_BYTES + 2)) begin
          g_kind = KIND_SUM_LO;
        end else begin
          g_kind  = KIND_SUM_HI;
          g_last  = 1'b1;
          g_final = 1'b1;
        end
      end
      MODE_ACK: begin
        g_byte = gstep[0] ? ACK_B : ACK_A;
        g_upd  = 1'b1;
        if (gstep == STEP_W'(3)) begin
          g_last  = 1'b1;
          g_final = 1'b1;
        end
      end
      MODE_COUNT: begin
        g_byte  = COUNT_BYTE;
        g_last  = 1'b1;
        g_final = 1'b1;
      end
      default: begin
        g_final = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (s1_kind)
      KIND_CONST:  sel_byte = s1_byte;
      KIND_MEM:    sel_byte = s1_zero ? 8'd0 : rd_data;
      KIND_SUM_LO: sel_byte = sum[7:0];
      default:     sel_byte = sum[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LOCKED;
      position <= 7'd0;
      bank     <= 1'b0;
      bank_ok  <= 2'b00;
    end else if (accept) begin
      phase    <= phase_next;
      position <= position_next;
      bank     <= bank_next;
      bank_ok  <= bank_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_CMD && rx_byte == CMD_WRITE) begin
      recv_sum <= 16'd0;
    end else if (mem_we) begin
      recv_sum <= recv_sum + {8'd0, rx_byte};
    end
    if (accept && phase == PH_RECV && position == 7'(TABLE_BYTES)) begin
      recv_lo <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_active <= 1'b0;
    end else if (gen_start && accept) begin
      gen_active <= 1'b1;
    end else if (issue && g_final) begin
      gen_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_start && accept) begin
      gen_mode <= gen_mode_start;
      gstep    <= '0;
    end else if (issue) begin
      gstep <= gstep + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind <= g_kind;
      s1_byte <= g_byte;
      s1_last <= g_last;
      s1_upd  <= g_upd;
      s1_zero <= !bank_ok[bank];
    end
  end

  always_ff @(posedge clk) begin
    if (gen_start && accept) begin
      sum <= 16'd0;
    end else if (s1_move && (s1_kind == KIND_CONST || s1_kind == KIND_MEM)) begin
      sum <= sum + {8'd0, sel_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (s1_move) begin
      tx_valid <= 1'b1;
    end else if (tx_ready) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      tx_byte       <= sel_byte;
      last          <= s1_last;
      table_updated <= s1_upd;
    end
  end

endmodule

### rtl/uttp_ram.sv
module uttp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/uttp_checker.sv
`include "assert_macros.svh"

module uttp_checker
  import uttp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       rx_ready,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] tx_byte,
  input logic       last,
  input logic       table_updated
);

  // A response byte that is not the last one still has its successor in flight.
  `ASSERT_IMPL(a_busy_mid_run, clk, rst, tx_valid && !last, !rx_ready)

  `ASSERT_IMPL(a_upd_is_ack, clk, rst, tx_valid && table_updated,
               tx_byte == ACK_A || tx_byte == ACK_B)

  `ASSERT_IMPL(a_upd_last_b, clk, rst, tx_valid && table_updated && last, tx_byte == ACK_B)

  `ASSERT_NEXT(a_tx_hold, clk, rst, tx_valid && !tx_ready,
               tx_valid && $stable(tx_byte) && $stable(last) && $stable(table_updated))

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !tx_valid && rx_ready)

endmodule

bind unlocked_table_transfer_protocol uttp_checker u_uttp_checker (.*);
